@@ src/pbd_pkg.sv @@
`default_nettype none

package pbd_pkg;

  // Geometry of the configuration port and the stream payloads.
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 24;
  localparam int unsigned PixelW     = 16;
  localparam int unsigned VbytesW    = 2;
  localparam int unsigned CountW     = 16;
  localparam int unsigned RunW       = 8;

  // Register map (byte addresses).
  localparam logic [ApbAddrW-1:0] RegImageBytes = 3'd0;

  localparam logic [CountW-1:0] ImageBytesReset = 16'd51840;
  localparam logic [CountW-1:0] CountMax        = 16'hFFFF;

  localparam logic [VbytesW-1:0] VbOne = 2'd1;
  localparam logic [VbytesW-1:0] VbTwo = 2'd2;

  typedef enum logic [3:0] {
    StHeader  = 4'b0001,
    StLiteral = 4'b0010,
    StRepVal  = 4'b0100,
    StRepEmit = 4'b1000
  } pbd_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_lit;
    logic load_rep;
    logic take_val;
    logic emit_lit;
    logic emit_rep;
  } pbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic limit_hit;
    logic hdr_lit;
    logic hdr_rep;
    logic lit_last;
    logic rep_last;
  } pbd_status_t;

endpackage

`default_nettype wire

@@ src/pbd_ctrl.sv @@
`default_nettype none

module pbd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pbd_pkg::pbd_status_t status_i,
  output pbd_pkg::pbd_cmd_t        cmd_o
);
  import pbd_pkg::*;

  pbd_state_e state_q, state_d;
  logic       in_fire;

  always_comb begin
    case (state_q)
      StHeader:  in_ready_o = 1'b1;
      StLiteral: in_ready_o = status_i.out_free;
      StRepVal:  in_ready_o = 1'b1;
      StRepEmit: in_ready_o = 1'b0;
      default:   in_ready_o = 1'b1;
    endcase
  end

  assign in_fire = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StHeader: begin
        // Headers are dropped once the image is complete; 128 is a no-op.
        if (in_fire && !status_i.limit_hit) begin
          if (status_i.hdr_lit) begin
            cmd_o.load_lit = 1'b1;
            state_d        = StLiteral;
          end else if (status_i.hdr_rep) begin
            cmd_o.load_rep = 1'b1;
            state_d        = StRepVal;
          end
        end
      end
      StLiteral: begin
        if (in_fire) begin
          cmd_o.emit_lit = 1'b1;
          if (status_i.lit_last) begin
            state_d = StHeader;
          end
        end
      end
      StRepVal: begin
        if (in_fire) begin
          cmd_o.take_val = 1'b1;
          state_d        = StRepEmit;
        end
      end
      StRepEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit_rep = 1'b1;
          if (status_i.rep_last) begin
            state_d = StHeader;
          end
        end
      end
      default: begin
        state_d = StHeader;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHeader;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/pbd_datapath.sv @@
`default_nettype none

module pbd_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [pbd_pkg::InDataW-1:0]         in_byte_i,
  input  wire pbd_pkg::pbd_cmd_t                   cmd_i,
  output pbd_pkg::pbd_status_t                     status_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [pbd_pkg::CountW-1:0]          cfg_wdata_i,
  output logic [pbd_pkg::CountW-1:0]               image_bytes_o,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic [pbd_pkg::PixelW-1:0]               out_pixel_o,
  output logic [pbd_pkg::VbytesW-1:0]              out_vbytes_o,
  output logic                                     out_last_o,
  output logic                                     out_done_o
);
  import pbd_pkg::*;

  logic [RunW-1:0]    left_q, left_d;
  logic [RunW-1:0]    value_q;
  logic [CountW-1:0]  count_q, count_d;
  logic [CountW-1:0]  image_bytes_q;
  logic               out_valid_q;
  logic [PixelW-1:0]  pixel_q;
  logic [VbytesW-1:0] vbytes_q;
  logic               last_q;
  logic               done_q;

  logic               emit;
  logic               rep_pair;
  logic [1:0]         nbytes;
  logic [CountW:0]    count_sum;

  assign emit     = cmd_i.emit_lit | cmd_i.emit_rep;
  assign rep_pair = (left_q[RunW-1:1] != '0);
  assign nbytes   = (cmd_i.emit_rep && rep_pair) ? 2'd2 : 2'd1;

  assign count_sum = {1'b0, count_q} + {{(CountW-1){1'b0}}, nbytes};
  assign count_d   = count_sum[CountW] ? CountMax : count_sum[CountW-1:0];

  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.limit_hit = (count_q >= image_bytes_q);
  assign status_o.hdr_lit   = !in_byte_i[7];
  assign status_o.hdr_rep   = in_byte_i[7] && (in_byte_i[6:0] != '0);
  assign status_o.lit_last  = (left_q == 8'd1);
  assign status_o.rep_last  = !rep_pair || (left_q == 8'd2);

  always_comb begin
    left_d = left_q;
    if (cmd_i.load_lit) begin
      left_d = in_byte_i + 8'd1;
    end else if (cmd_i.load_rep) begin
      left_d = 8'(9'd257 - {1'b0, in_byte_i});
    end else if (cmd_i.emit_lit) begin
      left_d = left_q - 8'd1;
    end else if (cmd_i.emit_rep) begin
      left_d = rep_pair ? (left_q - 8'd2) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q        <= '0;
      count_q       <= '0;
      image_bytes_q <= ImageBytesReset;
      out_valid_q   <= 1'b0;
    end else begin
      left_q <= left_d;
      if (emit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        image_bytes_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_val) begin
      value_q <= in_byte_i;
    end
    if (cmd_i.emit_lit) begin
      pixel_q  <= {in_byte_i, 8'h00};
      vbytes_q <= VbOne;
      last_q   <= status_o.lit_last;
      done_q   <= (count_d >= image_bytes_q);
    end else if (cmd_i.emit_rep) begin
      pixel_q  <= rep_pair ? {value_q, value_q} : {value_q, 8'h00};
      vbytes_q <= rep_pair ? VbTwo : VbOne;
      last_q   <= status_o.rep_last;
      done_q   <= (count_d >= image_bytes_q);
    end
  end

  assign image_bytes_o = image_bytes_q;
  assign out_valid_o   = out_valid_q;
  assign out_pixel_o   = pixel_q;
  assign out_vbytes_o  = vbytes_q;
  assign out_last_o    = last_q;
  assign out_done_o    = done_q;

endmodule

`default_nettype wire

@@ src/packbits_mono_bitmap_decoder_top.sv @@
// Channel   | Dir | Handshake                    | Payload
// s_axis    | in  | s_axis_tvalid / tready       | tdata[7:0] in_byte
// m_axis    | out | m_axis_tvalid / tready       | tdata pixel_bits, valid_bytes; tlast; tuser
// apb       | in  | psel, penable, pwrite, pready| image_bytes at address 0
//
// A header byte is always taken; a literal byte is taken when the output register is free
// and gives its beat in the next cycle. A repeat run takes the value byte and then gives
// ceil(count/2) output beats through the single output register, during which the input
// is held off. Reset is asynchronous and active low and needs no clearing pass.
// Backpressure on m_axis stalls the output register and, through it, s_axis.
`default_nettype none

module packbits_mono_bitmap_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream: tdata = in_byte[7:0].
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  // Output stream: tdata = pixel_bits[15:0], valid_bytes[17:16], zero[23:18].
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  // tuser = image_done[0].
  output logic             m_axis_tuser,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pbd_pkg::*;

  pbd_cmd_t             cmd;
  pbd_status_t          status;
  logic                 cfg_we;
  logic                 addr_hit;
  logic [CountW-1:0]    image_bytes;
  logic [PixelW-1:0]    pixel;
  logic [VbytesW-1:0]   vbytes;

  // The register file has a single entry; writes to any other address are dropped.
  assign pready   = 1'b1;
  assign addr_hit = (paddr == RegImageBytes);
  assign cfg_we   = psel & penable & pwrite & pready & addr_hit;
  assign prdata   = addr_hit ? {{(ApbDataW-CountW){1'b0}}, image_bytes} : '0;

  // The controller sequences headers, literal bytes and repeat runs.
  pbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the run counter, repeat value, byte count and output register.
  pbd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata[CountW-1:0]),
    .image_bytes_o (image_bytes),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_pixel_o   (pixel),
    .out_vbytes_o  (vbytes),
    .out_last_o    (m_axis_tlast),
    .out_done_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {{(OutDataW-PixelW-VbytesW){1'b0}}, vbytes, pixel};

endmodule

`default_nettype wire

@@ src/pbd_checker.sv @@
`default_nettype none

module pbd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // A stalled beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // Every beat carries one or two bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[17:16] == 2'd1 || m_axis_tdata[17:16] == 2'd2))
    else $error("valid byte count out of range");

  // A one-byte beat leaves the low byte clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17:16] == 2'd1 |-> m_axis_tdata[7:0] == 8'h00)
    else $error("low byte set on a one-byte beat");

  // Two-byte beats only come from repeat runs, so both bytes match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17:16] == 2'd2 |->
      m_axis_tdata[15:8] == m_axis_tdata[7:0])
    else $error("two-byte beat with differing bytes");

endmodule

bind packbits_mono_bitmap_decoder_top pbd_checker u_pbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ verif/packbits_beat_checker.sv @@
`default_nettype none

module packbits_beat_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_tvalid_i,
  input  wire logic                          s_tready_i,
  input  wire logic [pbd_pkg::InDataW-1:0]   s_tdata_i,
  input  wire logic                          m_tvalid_i,
  input  wire logic                          m_tready_i,
  input  wire logic [pbd_pkg::OutDataW-1:0]  m_tdata_i,
  input  wire logic                          m_tlast_i,
  input  wire logic                          m_tuser_i,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic                          pready_i,
  input  wire logic [pbd_pkg::ApbAddrW-1:0]  paddr_i,
  input  wire logic [pbd_pkg::ApbDataW-1:0]  pwdata_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o,
  output logic [pbd_pkg::CountW-1:0]         decoded_o,
  output logic                               at_header_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pbd_pkg::*;

  localparam logic [7:0] NoopHeader = 8'h80;

  typedef enum logic [1:0] {
    RunHeader,
    RunLiteral,
    RunRepeat
  } run_phase_e;

  typedef struct packed {
    logic [PixelW-1:0]  pixels;
    logic [VbytesW-1:0] nbytes;
    logic               last;
    logic               done;
  } pixel_beat_t;

  pixel_beat_t       beats_due[$];
  pixel_beat_t       seen;
  pixel_beat_t       due;
  run_phase_e        phase;
  logic [RunW-1:0]   run_left;
  logic [RunW:0]     repeat_left;
  logic [CountW-1:0] decoded;
  logic [CountW-1:0] image_limit;
  int unsigned       fails = 0;

  // Counts the bytes of one beat, saturating, and queues the beat.
  function automatic void queue_beat(input logic [PixelW-1:0] pixels,
                                     input logic [VbytesW-1:0] nbytes, input logic last);
    logic [CountW:0] sum;
    sum = {1'b0, decoded} + (CountW+1)'(nbytes);
    decoded = (sum > {1'b0, CountMax}) ? CountMax : sum[CountW-1:0];
    beats_due.push_back('{pixels, nbytes, last, decoded >= image_limit});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase       = RunHeader;
      run_left    = '0;
      decoded     = '0;
      image_limit = ImageBytesReset;
      fails       = 0;
      beats_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == RegImageBytes) begin
        image_limit = pwdata_i[CountW-1:0];
      end

      if (m_tvalid_i && m_tready_i) begin
        seen = '{m_tdata_i[PixelW-1:0], m_tdata_i[PixelW+VbytesW-1:PixelW], m_tlast_i,
                 m_tuser_i};
        if (beats_due.size() == 0) begin
          $error("pixel beat %h arrived with none expected", m_tdata_i);
          fails++;
        end else begin
          due = beats_due.pop_front();
          if (seen.pixels !== due.pixels) begin
            $error("pixel_bits: expected %h, got %h", due.pixels, seen.pixels);
            fails++;
          end
          if (seen.nbytes !== due.nbytes) begin
            $error("valid_bytes: expected %0d, got %0d", due.nbytes, seen.nbytes);
            fails++;
          end
          if (seen.last !== due.last) begin
            $error("run_last: expected %b, got %b", due.last, seen.last);
            fails++;
          end
          if (seen.done !== due.done) begin
            $error("image_done: expected %b, got %b", due.done, seen.done);
            fails++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        case (phase)
          RunLiteral: begin
            run_left = run_left - RunW'(1);
            if (run_left == 0) phase = RunHeader;
            queue_beat({s_tdata_i, 8'h00}, VbOne, run_left == 0);
          end
          RunRepeat: begin
            // The value byte expands to pairs, with a single byte left for odd counts.
            repeat_left = {1'b0, run_left};
            while (repeat_left >= 2) begin
              repeat_left = repeat_left - (RunW+1)'(2);
              queue_beat({s_tdata_i, s_tdata_i}, VbTwo, repeat_left == 0);
            end
            if (repeat_left == 1) queue_beat({s_tdata_i, 8'h00}, VbOne, 1'b1);
            run_left = '0;
            phase    = RunHeader;
          end
          default: begin
            phase = RunHeader;
            // Once the image is complete, headers are dropped without effect.
            if (decoded < image_limit) begin
              if (s_tdata_i < NoopHeader) begin
                run_left = s_tdata_i + RunW'(1);
                phase    = RunLiteral;
              end else if (s_tdata_i > NoopHeader) begin
                run_left = RunW'(9'd257 - {1'b0, s_tdata_i});
                phase    = RunRepeat;
              end
            end
          end
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= beats_due.size();
    decoded_o    <= decoded;
    at_header_o  <= (phase == RunHeader);
  end

endmodule

`default_nettype wire

@@ verif/packbits_mono_bitmap_decoder_top_tb.sv @@
`default_nettype none

module packbits_mono_bitmap_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbd_pkg::*;

  // Header byte that neither starts a run nor counts any bytes.
  localparam logic [7:0] NoopHeader    = 8'h80;
  // Header byte for the longest repeat run, 128 bytes in 64 beats.
  localparam logic [7:0] LongestRepeat = 8'h81;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Figures reported back by the checker; all are registered, so a value read right at
  // a clock edge shows the state from before that edge.
  int unsigned         fail_count;
  int unsigned         beats_pending;
  logic [CountW-1:0]   decoded_bytes;
  logic                at_run_header;

  // Each side switches now and then into a quiet stretch with no idle cycles at all.
  bit                  in_quiet;
  bit                  out_quiet;

  packbits_mono_bitmap_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  packbits_beat_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tuser_i    (m_axis_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (beats_pending),
    .decoded_o    (decoded_bytes),
    .at_header_o  (at_run_header)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Safety net: the slowest legal run stays well inside this bound.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Number of idle cycles before the next beat on one side.
  function automatic int unsigned draw_gap(inout bit quiet);
    if ($urandom_range(0, 15) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  // The receiver stalls for a fresh random count after every beat it takes. The count
  // runs down whether or not the block has anything to offer, so stalls land on every
  // phase of the decoder's work, including the middle of long repeat runs.
  initial begin : output_stalls
    int unsigned hold;
    hold = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        hold = draw_gap(out_quiet);
        if (hold != 0) m_axis_tready <= 1'b0;
      end else if (!m_axis_tready) begin
        if (hold != 0) hold--;
        if (hold == 0) m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one stream byte and returns at the edge that takes it. tvalid is left high,
  // so a following byte with no gap goes out back to back without a drop in between.
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = draw_gap(in_quiet);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // One random chunk of compressed stream. Most chunks are well-formed runs with random
  // content; the rest are no-op headers and stray bytes, which break the run structure
  // and shift the decoder's idea of where the next header sits.
  task automatic send_packet(output int unsigned items);
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 15);
    if (pick <= 6) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      send_byte(8'(len - 1));
      repeat (len) send_byte(8'($urandom));
      items = len + 1;
    end else if (pick <= 12) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 128) : $urandom_range(2, 16);
      send_byte(8'(257 - len));
      send_byte(8'($urandom));
      items = 2;
    end else if (pick == 13) begin
      send_byte(NoopHeader);
      items = 1;
    end else begin
      send_byte(8'($urandom));
      items = 1;
    end
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    int unsigned items;
    sent = 0;
    while (sent < target) begin
      send_packet(items);
      sent += items;
    end
  endtask

  // Brings the decoder to rest before a register write: any run still open is closed
  // with filler bytes, every expected beat is drained, and a few more cycles cover a
  // header that was taken but gives no beat.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (!at_run_header) begin
      send_byte(8'($urandom));
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    while (beats_pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge where
  // the access phase meets pready.
  task automatic write_image_bytes(input logic [CountW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegImageBytes;
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Opening stream at the reset image size: the shortest literal run with both extreme
  // byte values, a three-byte literal, a no-op header, the shortest repeat, an odd repeat
  // that ends in a single byte, and the longest repeat.
  localparam logic [7:0] Opening [14] = '{
    8'h00, 8'hFF,
    8'h02, 8'h80, 8'h01, 8'h7F,
    NoopHeader,
    8'hFF, 8'hA5,
    8'hFE, 8'h00,
    LongestRepeat, 8'h3C,
    8'h00
  };

  initial begin : stimulus
    int unsigned      guard;
    logic [CountW:0]  target;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The last opening byte starts a one-byte literal that settle() then closes.
    foreach (Opening[i]) send_byte(Opening[i]);
    settle();

    // Image complete: the limit sits three bytes ahead, a five-byte literal already
    // started runs past it to the end, and the headers after it are dropped.
    target = {1'b0, decoded_bytes} + (CountW+1)'(3);
    write_image_bytes(target[CountW-1:0]);
    send_byte(8'h04);
    repeat (5) send_byte(8'($urandom));
    send_byte(8'h82);
    send_byte(NoopHeader);
    send_byte(8'h05);
    settle();

    // A zero image size, and then the smallest legal one, both already reached: every
    // header is ignored.
    write_image_bytes('0);
    send_byte(8'h00);
    send_byte(8'h85);
    send_byte(NoopHeader);
    settle();
    write_image_bytes(16'd1);
    send_byte(8'h7F);
    send_byte(8'hC0);
    settle();

    // Random streams under three image sizes: the largest, one that is reached partway
    // through the phase, and the reset value.
    write_image_bytes(CountMax);
    run_random(30);
    settle();
    target = {1'b0, decoded_bytes} + (CountW+1)'($urandom_range(30, 150));
    write_image_bytes(target[CountW-1:0]);
    run_random(25);
    settle();
    write_image_bytes(ImageBytesReset);
    run_random(25);
    settle();

    // A closing one-byte literal of all-black pixels and a no-op header.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(NoopHeader);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    guard = 0;
    while (beats_pending != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (16) @(posedge clk_i);
    if (beats_pending != 0) $error("%0d pixel beats never arrived", beats_pending);
    if (fail_count == 0 && beats_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
src/pbd_pkg.sv
src/pbd_ctrl.sv
src/pbd_datapath.sv
src/packbits_mono_bitmap_decoder_top.sv
src/pbd_checker.sv
verif/packbits_beat_checker.sv
verif/packbits_mono_bitmap_decoder_top_tb.sv
